/* sv/dsfd_pkg.sv */
// Package for the dual-sync frame deframer: shared types and fixed codes.
// Used by the front, back and top modules of the deframer. It depends on nothing else.
package dsfd_pkg;

    localparam logic [7:0] SYNC_02 = 8'h02;
    localparam logic [7:0] SYNC_FF = 8'hFF;
    localparam logic [7:0] SYNC_AA = 8'hAA;

    localparam logic KIND_02   = 1'b0;
    localparam logic KIND_FFAA = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY
    } t_phase;

    // A received byte with its sync classification.
    typedef struct packed {
        logic [7:0] data;
        logic       is_02;
        logic       is_ff;
        logic       is_aa;
    } t_item;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [11:0] offset;
        logic        frame_kind;
        logic        last;
        logic [1:0]  status;
    } t_result;

endpackage

/* sv/dsfd_fifo.sv */
// Small synchronous queue built from registers, used between the deframer stages.
// Depends on nothing; the payload width and depth come from parameters.
module dsfd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Pointers wrap at the depth, which need not be a power of two.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + CW'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* sv/dsfd_front.sv */
// Front stage of the deframer: accepts bytes and tags them with sync classes.
// Depends on dsfd_pkg and dsfd_fifo; its queue feeds the frame parser.
module dsfd_front import dsfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_byte_in,
    output logic       o_full,
    input  logic       i_take,
    output t_item      o_item,
    output logic       o_item_valid
);

    t_item cls;
    logic  q_empty;

    always_comb begin
        cls.data  = i_byte_in;
        cls.is_02 = (i_byte_in == SYNC_02);
        cls.is_ff = (i_byte_in == SYNC_FF);
        cls.is_aa = (i_byte_in == SYNC_AA);
    end

    dsfd_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_data  (o_item),
        .o_empty (q_empty)
    );

    assign o_item_valid = !q_empty;

endmodule

/* sv/dsfd_back.sv */
// Back stage of the deframer: sync hunt, length parse, body tracking and XOR check.
// Depends on dsfd_pkg; takes classified bytes and pushes result items downstream.
module dsfd_back import dsfd_pkg::*; #(
    parameter int MAX_FRAME = 4096
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  logic    i_item_valid,
    output logic    o_take,
    output t_result o_res,
    output logic    o_res_push,
    input  logic    i_res_full
);

    localparam int PW = ($clog2(MAX_FRAME) > 12) ? $clog2(MAX_FRAME) : 12;
    localparam logic [31:0] LIM_02   = 32'(MAX_FRAME - 9);
    localparam logic [15:0] LIM_FFAA = 16'(MAX_FRAME - 4);

    t_phase        r_phase, n_phase;
    logic          r_kind, n_kind;
    logic [PW-1:0] r_pos, n_pos;
    logic [31:0]   r_len, n_len;
    logic [PW-1:0] r_last_pos, n_last_pos;
    logic [PW-1:0] r_chk_pos, n_chk_pos;
    logic [PW-1:0] r_xor_lim, n_xor_lim;
    logic [7:0]    r_xor, n_xor;
    logic          r_check, n_check;
    logic [1:0]    r_run02, n_run02;
    logic          r_prev_ff, n_prev_ff;

    logic [7:0]    b;
    logic [31:0]   len_next;
    logic [15:0]   m;
    logic          end_len;
    logic          bad;
    logic [PW-1:0] last_pos_new;
    logic [7:0]    xor_init;
    logic          clear;

    assign o_take = i_item_valid && !i_res_full;

    always_comb begin
        b            = i_item.data;
        len_next     = {r_len[23:0], b};
        m            = len_next[15:0];
        end_len      = (r_kind == KIND_02) ? (r_pos == PW'(7)) : (r_pos == PW'(3));
        bad          = (r_kind == KIND_02) ? (len_next > LIM_02)
                                           : ((m > LIM_FFAA) || (m < 16'd2));
        last_pos_new = len_next[PW-1:0] + ((r_kind == KIND_02) ? PW'(8) : PW'(3));
        // With short lengths the checked range covers only some length bytes.
        xor_init     = ((m >= 16'd3) ? r_len[7:0] : 8'd0) ^ ((m >= 16'd4) ? b : 8'd0);

        n_phase    = r_phase;
        n_kind     = r_kind;
        n_pos      = r_pos;
        n_len      = r_len;
        n_last_pos = r_last_pos;
        n_chk_pos  = r_chk_pos;
        n_xor_lim  = r_xor_lim;
        n_xor      = r_xor;
        n_check    = r_check;
        n_run02    = r_run02;
        n_prev_ff  = r_prev_ff;
        clear      = 1'b0;

        o_res.byte_out   = b;
        o_res.offset     = r_pos[11:0];
        o_res.frame_kind = r_kind;
        o_res.last       = 1'b0;
        o_res.status     = ST_OK;
        o_res_push       = 1'b0;

        if (o_take) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_item.is_02 && (r_run02 == 2'd3)) begin
                        clear   = 1'b1;
                        n_phase = PH_LEN;
                        n_kind  = KIND_02;
                        n_pos   = PW'(4);
                    end else if (i_item.is_aa && r_prev_ff) begin
                        clear   = 1'b1;
                        n_phase = PH_LEN;
                        n_kind  = KIND_FFAA;
                        n_pos   = PW'(2);
                    end else begin
                        n_run02   = i_item.is_02 ? ((r_run02 == 2'd3) ? 2'd3 : r_run02 + 2'd1)
                                                 : 2'd0;
                        n_prev_ff = i_item.is_ff;
                    end
                end
                PH_LEN: begin
                    o_res_push = 1'b1;
                    n_len      = len_next;
                    n_pos      = r_pos + PW'(1);
                    if (end_len) begin
                        if (bad) begin
                            o_res.last   = 1'b1;
                            o_res.status = ST_RANGE;
                            clear        = 1'b1;
                        end else begin
                            n_phase    = PH_BODY;
                            n_last_pos = last_pos_new;
                            n_chk_pos  = last_pos_new - PW'(2);
                            n_xor_lim  = last_pos_new - PW'(4);
                            if (r_kind == KIND_FFAA) begin
                                n_xor = xor_init;
                                if (m == 16'd2) begin
                                    n_check = (xor_init != b);
                                end
                            end
                        end
                    end
                end
                PH_BODY: begin
                    o_res_push = 1'b1;
                    if (r_kind == KIND_02) begin
                        if (r_pos == r_last_pos) begin
                            o_res.status = (r_xor != b) ? ST_MISMATCH : ST_OK;
                        end else begin
                            n_xor = r_xor ^ b;
                        end
                    end else begin
                        if (r_pos == r_chk_pos) begin
                            n_check = (r_xor != b);
                        end else if (r_pos <= r_xor_lim) begin
                            n_xor = r_xor ^ b;
                        end
                        if (r_pos == r_last_pos) begin
                            o_res.status = r_check ? ST_MISMATCH : ST_OK;
                        end
                    end
                    if (r_pos == r_last_pos) begin
                        o_res.last = 1'b1;
                        clear      = 1'b1;
                    end else begin
                        n_pos = r_pos + PW'(1);
                    end
                end
                default: begin
                    clear = 1'b1;
                end
            endcase
        end

        // Frame end, error end and a sync match all start from a clean slate.
        if (clear) begin
            n_run02   = 2'd0;
            n_prev_ff = 1'b0;
            n_xor     = 8'd0;
            n_check   = 1'b0;
            n_len     = '0;
            if (!(o_take && (r_phase == PH_HUNT))) begin
                n_phase = PH_HUNT;
                n_kind  = KIND_02;
                n_pos   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_kind    <= KIND_02;
            r_pos     <= '0;
            r_len     <= '0;
            r_xor     <= 8'd0;
            r_check   <= 1'b0;
            r_run02   <= 2'd0;
            r_prev_ff <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_kind    <= n_kind;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_xor     <= n_xor;
            r_check   <= n_check;
            r_run02   <= n_run02;
            r_prev_ff <= n_prev_ff;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_pos <= n_last_pos;
        r_chk_pos  <= n_chk_pos;
        r_xor_lim  <= n_xor_lim;
    end

endmodule

/* sv/dual_sync_frame_deframer_xor.sv */
// Top level of the dual-sync frame deframer with XOR frame check.
// Depends on dsfd_pkg, dsfd_front, dsfd_back and dsfd_fifo.
//
// Usage: received bytes enter on i_byte_in; a transfer happens on a clock
// edge where push is high and full is low. Result items leave as a queue:
// while empty is low the oldest result is on the o_ ports, and a transfer
// happens on an edge where pop is high. Sync bytes give no result; every
// byte after a sync pattern gives one, tagged with its offset and kind,
// and the final byte (or the length byte of an out-of-range frame) has
// o_last set along with its status.
// Path: a transferred byte is registered in the input queue, then parsed
// and registered in the result queue. Throughput: one byte per cycle while the
// result queue has room, limited by the single parse step of the back stage.
// Reset clears both queues and returns the parser to hunting for sync.
// When the receiver stalls, the two-entry result queue fills, the parser
// stops, the four-entry input queue fills and full rises; nothing is lost.
module dual_sync_frame_deframer_xor import dsfd_pkg::*; #(
    parameter int MAX_FRAME = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_byte_in,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_byte_out,
    output logic [11:0] o_offset,
    output logic        o_frame_kind,
    output logic        o_last,
    output logic [1:0]  o_status
);

    t_item   item;
    logic    item_valid;
    logic    take;
    t_result res;
    logic    res_push;
    logic    res_full;
    t_result res_head;

    dsfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_byte_in    (i_byte_in),
        .o_full       (full),
        .i_take       (take),
        .o_item       (item),
        .o_item_valid (item_valid)
    );

    dsfd_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_take       (take),
        .o_res        (res),
        .o_res_push   (res_push),
        .i_res_full   (res_full)
    );

    dsfd_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty)
    );

    assign o_byte_out   = res_head.byte_out;
    assign o_offset     = res_head.offset;
    assign o_frame_kind = res_head.frame_kind;
    assign o_last       = res_head.last;
    assign o_status     = res_head.status;

endmodule

/* bench/tb.sv */
// Testbench for the dual-sync frame deframer with XOR frame check.
// Depends on dsfd_pkg and dual_sync_frame_deframer_xor; bytes are checked
// against a cycle-free predictor of the parser kept in a scoreboard class.
module tb import dsfd_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FRAME = 4096;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_byte_in;
    logic        empty;
    logic        pop;
    logic [7:0]  o_byte_out;
    logic [11:0] o_offset;
    logic        o_frame_kind;
    logic        o_last;
    logic [1:0]  o_status;

    // Predicts the result of every accepted byte and checks the results.
    class deframe_tracker;
        logic [31:0] sync_win;
        t_phase      phase;
        logic        kind;
        int          pos;
        logic [31:0] span;     // length accumulator, then total frame size
        logic [7:0]  xsum;
        logic        sum_bad;  // checksum verdict of an FF AA frame
        t_result     due_q[$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            sync_win = '0;
            phase    = PH_HUNT;
            kind     = KIND_02;
            pos      = 0;
            span     = '0;
            xsum     = '0;
            sum_bad  = 1'b0;
        endfunction

        function t_result frame_byte(logic [7:0] b, logic is_last, logic [1:0] st);
            t_result r;
            r.byte_out   = b;
            r.offset     = pos[11:0];
            r.frame_kind = kind;
            r.last       = is_last;
            r.status     = st;
            return r;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [31:0] prev;
            logic [63:0] need;
            logic [15:0] m;
            logic        end_len;
            logic        bad;
            logic        fin;
            logic [1:0]  st;
            case (phase)
                PH_LEN: begin
                    prev = span;
                    span = {span[23:0], b};
                    end_len = (kind == KIND_02) ? (pos == 7) : (pos == 3);
                    if (end_len) begin
                        m = span[15:0];
                        if (kind == KIND_02) begin
                            need = {32'd0, span} + 64'd9;
                            bad  = need > MAX_FRAME;
                        end else begin
                            need = {48'd0, m} + 64'd4;
                            bad  = (need > MAX_FRAME) || (m < 2);
                        end
                        if (bad) begin
                            due_q.push_back(frame_byte(b, 1'b1, ST_RANGE));
                            restart();
                            return;
                        end
                        span = need[31:0];
                        // Short FF AA frames check bytes that lie in the length field.
                        if (kind == KIND_FFAA) begin
                            xsum = ((m >= 3) ? prev[7:0] : 8'd0) ^ ((m >= 4) ? b : 8'd0);
                            if (m == 2)
                                sum_bad = (xsum != b);
                        end
                        phase = PH_BODY;
                    end
                    due_q.push_back(frame_byte(b, 1'b0, ST_OK));
                    pos++;
                end
                PH_BODY: begin
                    fin = (pos == int'(span) - 1);
                    st  = ST_OK;
                    if (kind == KIND_02) begin
                        if (fin)
                            st = (xsum != b) ? ST_MISMATCH : ST_OK;
                        else
                            xsum ^= b;
                    end else begin
                        if (pos == int'(span) - 3)
                            sum_bad = (xsum != b);
                        else if (pos <= int'(span) - 5)
                            xsum ^= b;
                        if (fin)
                            st = sum_bad ? ST_MISMATCH : ST_OK;
                    end
                    due_q.push_back(frame_byte(b, fin, st));
                    if (fin)
                        restart();
                    else
                        pos++;
                end
                default: begin
                    sync_win = {sync_win[23:0], b};
                    if (sync_win == {4{SYNC_02}}) begin
                        restart();
                        phase = PH_LEN;
                        pos   = 4;
                    end else if (sync_win[15:0] == {SYNC_FF, SYNC_AA}) begin
                        restart();
                        kind  = KIND_FFAA;
                        phase = PH_LEN;
                        pos   = 2;
                    end
                end
            endcase
        endfunction

        function void check_output(t_result got);
            t_result want;
            if (due_q.size() == 0) begin
                $error("unexpected result: byte_out %0h offset %0d", got.byte_out, got.offset);
                errors++;
                return;
            end
            want = due_q.pop_front();
            if (got.byte_out !== want.byte_out) begin
                $error("byte_out: expected %0h, got %0h", want.byte_out, got.byte_out);
                errors++;
            end
            if (got.offset !== want.offset) begin
                $error("offset: expected %0d, got %0d", want.offset, got.offset);
                errors++;
            end
            if (got.frame_kind !== want.frame_kind) begin
                $error("frame_kind: expected %0d, got %0d", want.frame_kind, got.frame_kind);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    deframe_tracker tracker = new();

    logic [7:0] tx[$];
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         hold_wanted;

    dual_sync_frame_deframer_xor #(
        .MAX_FRAME(MAX_FRAME)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_byte_in   (i_byte_in),
        .empty       (empty),
        .pop         (pop),
        .o_byte_out  (o_byte_out),
        .o_offset    (o_offset),
        .o_frame_kind(o_frame_kind),
        .o_last      (o_last),
        .o_status    (o_status)
    );

    always #5 i_clk = ~i_clk;

    task automatic add_frame(logic kind, int len, bit corrupt);
        logic [7:0]  f[$];
        logic [7:0]  x;
        logic [7:0]  b;
        logic [31:0] l32;
        l32 = len;
        x = 8'd0;
        if (kind == KIND_02) begin
            repeat (4) f.push_back(SYNC_02);
            for (int i = 3; i >= 0; i--)
                f.push_back(l32[8*i +: 8]);
            repeat (len) begin
                b = 8'($urandom_range(0, 255));
                x ^= b;
                f.push_back(b);
            end
            f.push_back(corrupt ? x ^ 8'($urandom_range(1, 255)) : x);
        end else begin
            f = {SYNC_FF, SYNC_AA, l32[15:8], l32[7:0]};
            repeat (len) f.push_back(8'($urandom_range(0, 255)));
            // The check range starts at the length bytes.
            if (len >= 3) begin
                for (int i = 2; i < len; i++)
                    x ^= f[i];
                f[len + 1] = corrupt ? x ^ 8'($urandom_range(1, 255)) : x;
            end
        end
        foreach (f[i]) tx.push_back(f[i]);
    endtask

    task automatic add_bad_length(logic kind, logic [31:0] len);
        if (kind == KIND_02) begin
            repeat (4) tx.push_back(SYNC_02);
            for (int i = 3; i >= 0; i--)
                tx.push_back(len[8*i +: 8]);
        end else begin
            tx.push_back(SYNC_FF);
            tx.push_back(SYNC_AA);
            tx.push_back(len[15:8]);
            tx.push_back(len[7:0]);
        end
    endtask

    task automatic load_directed();
        add_frame(KIND_02, 0, 0);
        // Payload at both byte extremes.
        repeat (4) tx.push_back(SYNC_02);
        tx.push_back(8'h00); tx.push_back(8'h00); tx.push_back(8'h00); tx.push_back(8'h02);
        tx.push_back(8'h00); tx.push_back(8'hFF); tx.push_back(8'hFF);
        add_frame(KIND_02, 5, 1);
        add_bad_length(KIND_FFAA, 0);
        add_bad_length(KIND_FFAA, 1);
        add_frame(KIND_FFAA, 2, 0);
        add_frame(KIND_FFAA, 3, 0);
        add_frame(KIND_FFAA, 4, 0);
        add_frame(KIND_FFAA, 6, 1);
        add_bad_length(KIND_02, MAX_FRAME - 8);
        add_bad_length(KIND_02, 32'hFFFF_FFFF);
        add_bad_length(KIND_FFAA, MAX_FRAME - 3);
        add_bad_length(KIND_FFAA, 32'h0000_FFFF);
        // Overlapping sync patterns: the first one to complete wins.
        repeat (3) tx.push_back(SYNC_02);
        add_frame(KIND_FFAA, 5, 0);
        tx.push_back(SYNC_FF);
        add_frame(KIND_02, 3, 0);
        tx.push_back(SYNC_FF);
        add_frame(KIND_FFAA, 4, 0);
        tx.push_back(SYNC_02);
        add_frame(KIND_02, 1, 0);
    endtask

    task automatic add_random(int target);
        int         pick;
        logic [7:0] b;
        while (tx.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                if ($urandom_range(0, 1) == 0)
                    add_frame(KIND_02, $urandom_range(0, 40), $urandom_range(0, 4) == 0);
                else
                    add_frame(KIND_FFAA, $urandom_range(2, 44), $urandom_range(0, 4) == 0);
            end else if (pick < 80) begin
                case ($urandom_range(0, 3))
                    0: add_bad_length(KIND_02, $urandom_range(32'hFFFF_FFFF, MAX_FRAME - 8));
                    1: add_bad_length(KIND_FFAA, $urandom_range(1, 0));
                    default: add_bad_length(KIND_FFAA, $urandom_range(65535, MAX_FRAME - 3));
                endcase
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 6)) tx.push_back(8'($urandom_range(0, 255)));
            end else begin
                // A sync pattern cut short by a wrong byte.
                if ($urandom_range(0, 1) == 0) begin
                    repeat ($urandom_range(1, 3)) tx.push_back(SYNC_02);
                    do b = 8'($urandom_range(0, 255)); while (b == SYNC_02);
                end else begin
                    tx.push_back(SYNC_FF);
                    do b = 8'($urandom_range(0, 255)); while (b == SYNC_AA);
                end
                tx.push_back(b);
            end
        end
    endtask

    task automatic send_stream();
        logic [7:0] b;
        bit         done;
        while (tx.size() > 0) begin
            b = tx.pop_front();
            done = 0;
            while (!done) begin
                @(negedge i_clk);
                if ($urandom_range(0, 99) < send_idle_pct) begin
                    push <= 1'b0;
                    i_byte_in <= 8'($urandom_range(0, 255));
                end else begin
                    push <= 1'b1;
                    i_byte_in <= b;
                end
                @(posedge i_clk);
                if (push && !full) begin
                    tracker.note_byte(b);
                    done = 1;
                end
            end
        end
    endtask

    // Result side: random pops, plus one long hold-off that backs up the input.
    initial begin
        int      hold_left;
        bit      hold_used;
        t_result got;
        hold_left = 0;
        hold_used = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_wanted && !hold_used) begin
                hold_left = 300;
                hold_used = 1;
            end
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
            @(posedge i_clk);
            if (pop && !empty) begin
                got.byte_out   = o_byte_out;
                got.offset     = o_offset;
                got.frame_kind = o_frame_kind;
                got.last       = o_last;
                got.status     = o_status;
                tracker.check_output(got);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_byte_in = 8'd0;
        hold_wanted = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        load_directed();
        add_random(500);
        send_idle_pct = 6;
        recv_idle_pct = 82;
        send_stream();

        add_random(500);
        send_idle_pct = 82;
        recv_idle_pct = 6;
        send_stream();

        add_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_wanted = 1;
        send_stream();

        @(negedge i_clk);
        push <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
sv/dsfd_pkg.sv
sv/dsfd_fifo.sv
sv/dsfd_front.sv
sv/dsfd_back.sv
sv/dual_sync_frame_deframer_xor.sv
bench/tb.sv
